// ----- rtl/ccbs_pkg.sv -----
// ----------------------------------------------------------------------------
// ccbs_pkg
// Shared types and constants for the C chunk bracket scanner.
// ----------------------------------------------------------------------------
package ccbs_pkg;

    // Saturation bound of the internal bracket depth
    localparam int DEPTH_LIMIT = 127;
    // Signed width that holds +/- DEPTH_LIMIT
    localparam int DEPTH_W = $clog2(DEPTH_LIMIT + 1) + 1;
    // Reported depth bound and width
    localparam int OUT_LIMIT = 127;
    localparam int OUT_W = 8;
    // Width used for the output clamp compare
    localparam int CMP_W = ((DEPTH_W > OUT_W) ? DEPTH_W : OUT_W) + 1;

    // Item kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_EOL  = 1'b1;

    // Character codes
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // Lexer modes
    typedef enum logic [2:0] {
        MODE_CODE  = 3'd0,
        MODE_STR   = 3'd1,
        MODE_CHR   = 3'd2,
        MODE_LINE  = 3'd3,
        MODE_BLOCK = 3'd4
    } lex_mode_t;

    // Scanner state
    typedef struct packed {
        logic signed [DEPTH_W-1:0] depth;
        lex_mode_t                 mode;
        logic                      slash;
        logic                      star;
        logic                      esc;
        logic                      seen;
    } scan_state_t;

    // One result item
    typedef struct packed {
        logic signed [OUT_W-1:0] nest_depth;
        logic                    inside_string;
        logic                    inside_char;
        logic                    inside_comment;
        logic                    chunk_end;
        logic                    chunk_nonblank;
    } scan_result_t;

endpackage

// ----- rtl/ccbs_step.sv -----
// ----------------------------------------------------------------------------
// ccbs_step
// Next-state and result logic for one scanner item.
// ----------------------------------------------------------------------------
module ccbs_step
    import ccbs_pkg::*;
(
    input  scan_state_t  cur,
    input  logic         kind,
    input  logic [7:0]   char_code,
    input  logic         final_line,
    output scan_state_t  nxt,
    output scan_result_t res
);

    logic                      is_blank;
    logic                      is_open;
    logic                      is_close;
    logic signed [DEPTH_W:0]   bumped;
    logic                      code_path;
    logic                      chunk_end;
    logic                      chunk_nonblank;
    logic signed [CMP_W-1:0]   depth_wide;

    // Character classes
    always_comb
    begin
        is_blank = 1'b0;
        is_open  = 1'b0;
        is_close = 1'b0;
        case (char_code) inside
            CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: is_blank = 1'b1;
            CH_LBRACE, CH_LPAREN, CH_LBRACK:              is_open  = 1'b1;
            CH_RBRACE, CH_RPAREN, CH_RBRACK:              is_close = 1'b1;
            default: ;
        endcase
    end

    // Saturating depth update
    always_comb
    begin
        bumped = {cur.depth[DEPTH_W-1], cur.depth};
        if (is_open)
            bumped = bumped + (DEPTH_W+1)'(1);
        else if (is_close)
            bumped = bumped - (DEPTH_W+1)'(1);
        if (bumped > (DEPTH_W+1)'(DEPTH_LIMIT))
            bumped = (DEPTH_W+1)'(DEPTH_LIMIT);
        else if (bumped < -(DEPTH_W+1)'(DEPTH_LIMIT))
            bumped = -(DEPTH_W+1)'(DEPTH_LIMIT);
    end

    // Mode machine
    always_comb
    begin
        nxt            = cur;
        code_path      = 1'b0;
        chunk_end      = 1'b0;
        chunk_nonblank = 1'b0;
        if (kind == KIND_CHAR)
        begin
            if (!is_blank)
                nxt.seen = 1'b1;
            unique case (cur.mode) inside
                MODE_LINE: ;
                MODE_BLOCK:
                begin
                    if (cur.star && char_code == CH_SLASH)
                    begin
                        nxt.mode = MODE_CODE;
                        nxt.star = 1'b0;
                    end
                    else
                        nxt.star = (char_code == CH_STAR);
                end
                MODE_STR, MODE_CHR:
                begin
                    if (cur.esc)
                        nxt.esc = 1'b0;
                    else if (char_code == CH_BSLASH)
                        nxt.esc = 1'b1;
                    else if ((cur.mode == MODE_STR && char_code == CH_DQUOTE) ||
                             (cur.mode == MODE_CHR && char_code == CH_SQUOTE))
                        nxt.mode = MODE_CODE;
                end
                default:
                begin
                    // Normal code, also unused mode codes
                    nxt.mode = MODE_CODE;
                    if (cur.slash)
                    begin
                        nxt.slash = 1'b0;
                        if (char_code == CH_SLASH)
                            nxt.mode = MODE_LINE;
                        else if (char_code == CH_STAR)
                        begin
                            nxt.mode = MODE_BLOCK;
                            nxt.star = 1'b0;
                        end
                        else
                            code_path = 1'b1;
                    end
                    else
                        code_path = 1'b1;
                end
            endcase
            if (code_path)
            begin
                if (char_code == CH_DQUOTE)
                    nxt.mode = MODE_STR;
                else if (char_code == CH_SQUOTE)
                    nxt.mode = MODE_CHR;
                else if (char_code == CH_SLASH)
                    nxt.slash = 1'b1;
                else
                    nxt.depth = bumped[DEPTH_W-1:0];
            end
        end
        else
        begin
            // Line end: literals and line comments close, lookahead clears
            if (cur.mode != MODE_BLOCK)
                nxt.mode = MODE_CODE;
            nxt.slash = 1'b0;
            nxt.star  = 1'b0;
            nxt.esc   = 1'b0;
            if (final_line || (cur.depth <= 0 && cur.mode != MODE_BLOCK))
            begin
                chunk_end      = 1'b1;
                chunk_nonblank = cur.seen;
                nxt.depth      = '0;
                nxt.seen       = 1'b0;
            end
        end
    end

    // Reported fields
    always_comb
    begin
        depth_wide = CMP_W'(nxt.depth);
        if (depth_wide > CMP_W'(OUT_LIMIT))
            depth_wide = CMP_W'(OUT_LIMIT);
        else if (depth_wide < -CMP_W'(OUT_LIMIT))
            depth_wide = -CMP_W'(OUT_LIMIT);
        res.nest_depth     = depth_wide[OUT_W-1:0];
        res.inside_string  = (nxt.mode == MODE_STR);
        res.inside_char    = (nxt.mode == MODE_CHR);
        res.inside_comment = (nxt.mode == MODE_BLOCK);
        res.chunk_end      = chunk_end;
        res.chunk_nonblank = chunk_nonblank;
    end

endmodule

// ----- rtl/c_chunk_bracket_scanner.sv -----
// ----------------------------------------------------------------------------
// c_chunk_bracket_scanner
// Bracket depth and chunk boundary scanner for a stream of C source bytes.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                         | tuser | tlast
//  s_*     | in  | char_code                     | kind  | final_line
//  m_*     | out | depth, str, chr, cmt, nonblank| -     | chunk_end
//
//  One request per cycle while m_tready is high: the state update and result
//  are one combinational step from the state registers into the result register.
//  m_tvalid is set in the cycle after a request is accepted.
//  rst_n clears the scanner state and the result valid flag.
//  The result register holds under m_tready low; s_tready follows
//  m_tready whenever a result is waiting.
// ----------------------------------------------------------------------------
module c_chunk_bracket_scanner
    import ccbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tuser,   // kind
    input  logic        s_tlast,   // final_line
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] nest_depth, [8] inside_string,
                                   // [9] inside_char, [10] inside_comment,
                                   // [11] chunk_nonblank, [15:12] zero
    output logic        m_tlast    // chunk_end
);

    scan_state_t  state_reg;
    scan_state_t  state_next;
    scan_result_t res_reg;
    scan_result_t res_next;
    logic         valid_reg;
    logic         accept;

    assign s_tready = !valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    ccbs_step u_step (
        .cur        (state_reg),
        .kind       (s_tuser),
        .char_code  (s_tdata),
        .final_line (s_tlast),
        .nxt        (state_next),
        .res        (res_next)
    );

    // Scanner state and valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{depth: '0, mode: MODE_CODE, slash: 1'b0,
                           star: 1'b0, esc: 1'b0, seen: 1'b0};
            valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
                valid_reg <= 1'b1;
            end
            else if (m_tready)
                valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'b0000, res_reg.chunk_nonblank, res_reg.inside_comment,
                       res_reg.inside_char, res_reg.inside_string,
                       res_reg.nest_depth};
    assign m_tlast  = res_reg.chunk_end;

    // A closed chunk reports zero depth
    a_chunk_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (res_reg.nest_depth == '0))
        else $error("chunk end with nonzero depth");

    // Nonblank only comes with a chunk end
    a_nonblank: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && res_reg.chunk_nonblank) |-> res_reg.chunk_end)
        else $error("nonblank without chunk end");

    // At most one literal or comment mode
    a_modes: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot0({res_reg.inside_string, res_reg.inside_char,
                               res_reg.inside_comment}))
        else $error("several modes reported");

    // Slash lookahead only lives in code mode
    a_slash: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.slash |-> (state_reg.mode == MODE_CODE))
        else $error("slash pending outside code");

    // Depth stays within the limit
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.depth <= DEPTH_W'(DEPTH_LIMIT)) &&
        (state_reg.depth >= -DEPTH_W'(DEPTH_LIMIT)))
        else $error("depth out of range");

endmodule
